[src/facet_tilt_histogram_macros.svh]
// assertion macros for the facet tilt histogram
// used by fth_back.sv, no other dependencies
`ifndef FACET_TILT_HISTOGRAM_MACROS_SVH
`define FACET_TILT_HISTOGRAM_MACROS_SVH
// condition holds at every clock out of reset
`define FTH_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define FTH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define FTH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[src/fth_pkg.sv]
// shared constants, item types and the squared cosine table of the tilt histogram
// no dependencies
package fth_pkg;

   localparam int NORMAL_BITS        = 16;
   localparam int TOTAL_BITS_DEFAULT = 32;
   localparam int OUT_BITS           = 32;
   localparam int TILT_BITS          = 8;
   localparam int MAG_BITS           = NORMAL_BITS + 1;
   localparam int S_BITS             = 2 * NORMAL_BITS;
   localparam int ROOT_BITS          = NORMAL_BITS;
   localparam int INC_BITS           = NORMAL_BITS + 1;
   localparam int HALF_RANGE         = 90;
   localparam int BIN_COUNT          = 2 * HALF_RANGE + 1;
   localparam int IDX_BITS           = $clog2(BIN_COUNT);
   localparam int SEARCH_BITS        = $clog2(HALF_RANGE + 2);
   localparam int CSQ_BITS           = 61;
   localparam int CSQ_LO_BITS        = 30;
   localparam int CSQ_HI_BITS        = CSQ_BITS - CSQ_LO_BITS;
   localparam int TAYLOR_TERMS       = 12;
   localparam logic [63:0] DEG_Q30   = 64'd18740330;
   localparam logic [63:0] ONE_Q30   = 64'd1 << 30;

   typedef logic [CSQ_BITS-1:0] csq_table_type [0:HALF_RANGE];

   typedef struct packed {
      logic [S_BITS-1:0]   sum_sq;
      logic [S_BITS-1:0]   z_sq;
      logic                z_pos;
      logic                z_neg;
      logic                zero;
      logic [INC_BITS-1:0] inc;
   } work_type;

   typedef struct packed {
      logic signed [TILT_BITS-1:0] tilt_bin;
      logic [OUT_BITS-1:0]         bin_total;
      logic [OUT_BITS-1:0]         peak_total;
      logic                        zero_normal;
   } result_type;

   // cos(d deg)^2 in Q60 from a truncating taylor series in Q30
   function automatic csq_table_type build_csq();
      csq_table_type t;
      logic [63:0]   x;
      logic [63:0]   x2;
      logic [63:0]   term;
      logic [63:0]   c;
      longint        sum;
      for (int d = 0; d < HALF_RANGE; d++) begin
         x    = 64'(d) * DEG_Q30;
         x2   = (x * x) >> 30;
         term = ONE_Q30;
         sum  = longint'(ONE_Q30);
         for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         c    = (sum < 0) ? 64'd0 : 64'(sum);
         t[d] = CSQ_BITS'(c * c);
      end
      t[HALF_RANGE] = '0;
      return t;
   endfunction

   localparam csq_table_type CSQ = build_csq();

endpackage

[src/fth_fifo.sv]
// small register queue used between the stages and on the result side
// no dependencies
module fth_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (do_pop)  rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 1'b1;
      end
   end
endmodule

[src/fth_front.sv]
// front part: takes a normal, forms the squared length and the rounded length
// depends on fth_pkg
module fth_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic signed [fth_pkg::NORMAL_BITS-1:0] normal_x,
   input  logic signed [fth_pkg::NORMAL_BITS-1:0] normal_y,
   input  logic signed [fth_pkg::NORMAL_BITS-1:0] normal_z,
   output logic                              work_push,
   output fth_pkg::work_type                 work_data,
   input  logic                              work_full
);
   localparam int N     = fth_pkg::NORMAL_BITS;
   localparam int MW    = fth_pkg::MAG_BITS;
   localparam int SW    = fth_pkg::S_BITS;
   localparam int RW    = fth_pkg::ROOT_BITS;
   localparam int REM_W = N + 3;
   localparam int CW    = (RW > 1) ? $clog2(RW) : 1;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_SQ   = 2'd1;
   localparam logic [1:0] F_ROOT = 2'd2;
   localparam logic [1:0] F_PUSH = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [MW-1:0]    ax_ff, ay_ff, az_ff, op;
   logic             zneg_ff;
   logic [1:0]       step_ff;
   logic [SW-1:0]    acc_ff, z2_ff, shift_ff, sq;
   logic [2*MW-1:0]  prod;
   logic [REM_W-1:0] rem_ff, rem_sh, trial;
   logic [RW-1:0]    root_ff;
   logic [CW-1:0]    cnt_ff;

   function automatic logic [MW-1:0] mag(input logic signed [N-1:0] v);
      logic signed [MW-1:0] e;
      e = MW'(v);
      return v[N-1] ? MW'(-e) : MW'(e);
   endfunction

   always_comb begin
      unique case (step_ff)
         2'd0:    op = ax_ff;
         2'd1:    op = ay_ff;
         default: op = az_ff;
      endcase
   end
   assign prod   = op * op;
   assign sq     = prod[SW-1:0];
   assign rem_sh = {rem_ff[REM_W-3:0], shift_ff[SW-1:SW-2]};
   assign trial  = REM_W'({root_ff, 2'b01});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (push) state_in = F_SQ;
         F_SQ:    if (step_ff == 2'd2) state_in = F_ROOT;
         F_ROOT:  if (cnt_ff == '0) state_in = F_PUSH;
         default: if (!work_full) state_in = F_IDLE;
      endcase
   end

   assign full      = (state_ff != F_IDLE);
   assign work_push = (state_ff == F_PUSH);

   always_comb begin
      work_data.sum_sq = acc_ff;
      work_data.z_sq   = z2_ff;
      work_data.zero   = (acc_ff == '0);
      work_data.z_pos  = !zneg_ff && (az_ff != '0);
      work_data.z_neg  = zneg_ff;
      work_data.inc    = fth_pkg::INC_BITS'(root_ff) +
                         fth_pkg::INC_BITS'(rem_ff > REM_W'(root_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= F_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         F_IDLE: begin
            ax_ff   <= mag(normal_x);
            ay_ff   <= mag(normal_y);
            az_ff   <= mag(normal_z);
            zneg_ff <= normal_z[N-1];
            step_ff <= '0;
            acc_ff  <= '0;
         end
         F_SQ: begin
            acc_ff  <= acc_ff + sq;
            step_ff <= step_ff + 1'b1;
            if (step_ff == 2'd2) begin
               z2_ff    <= sq;
               shift_ff <= acc_ff + sq;
               rem_ff   <= '0;
               root_ff  <= '0;
               cnt_ff   <= CW'(RW - 1);
            end
         end
         F_ROOT: begin
            // one root bit per cycle, restoring form
            shift_ff <= shift_ff << 2;
            cnt_ff   <= cnt_ff - 1'b1;
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[RW-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[RW-2:0], 1'b0};
            end
         end
         default: ;
      endcase
   end
endmodule

[src/fth_back.sv]
// back part: angle bin search over the cosine table and histogram update
// depends on fth_pkg and facet_tilt_histogram_macros.svh
`include "facet_tilt_histogram_macros.svh"
module fth_back #(
   parameter int TOTAL_BITS = fth_pkg::TOTAL_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                work_empty,
   output logic                work_pop,
   input  fth_pkg::work_type   work_data,
   output logic                res_push,
   output fth_pkg::result_type res_data,
   input  logic                res_full
);
   localparam int SW    = fth_pkg::S_BITS;
   localparam int SB    = fth_pkg::SEARCH_BITS;
   localparam int IB    = fth_pkg::IDX_BITS;
   localparam int LO_W  = fth_pkg::CSQ_LO_BITS;
   localparam int HI_W  = fth_pkg::CSQ_HI_BITS;
   localparam int CMP_W = SW + fth_pkg::CSQ_BITS;
   localparam int SUM_W = ((TOTAL_BITS > fth_pkg::INC_BITS) ? TOTAL_BITS
                                                             : fth_pkg::INC_BITS) + 1;
   localparam int OB    = fth_pkg::OUT_BITS;

   localparam logic [3:0] B_IDLE = 4'd0;
   localparam logic [3:0] B_CHK  = 4'd1;
   localparam logic [3:0] B_PLO  = 4'd2;
   localparam logic [3:0] B_PHI  = 4'd3;
   localparam logic [3:0] B_SUM  = 4'd4;
   localparam logic [3:0] B_CMP  = 4'd5;
   localparam logic [3:0] B_READ = 4'd6;
   localparam logic [3:0] B_ADD  = 4'd7;
   localparam logic [3:0] B_EMIT = 4'd8;

   logic [3:0]              state_ff, state_in;
   fth_pkg::work_type       item_ff;
   logic [SB-1:0]           lo_ff, hi_ff, mid_ff;
   logic [SB:0]             mid_sum;
   logic [fth_pkg::CSQ_BITS-1:0] csq;
   logic [HI_W-1:0]         mul_op;
   logic [SW+HI_W-1:0]      prod;
   logic [SW+HI_W-1:0]      plo_ff, phi_ff;
   logic [CMP_W-1:0]        rhs_ff, lhs;
   logic                    pred;
   logic [IB-1:0]           idx_ff;
   logic [TOTAL_BITS-1:0]   mem [0:fth_pkg::BIN_COUNT-1];
   logic [fth_pkg::BIN_COUNT-1:0] valid_ff;
   logic [TOTAL_BITS-1:0]   rd_ff, cur, total_in;
   logic                    rd_valid_ff;
   logic [SUM_W-1:0]        sum;
   logic [TOTAL_BITS-1:0]   peak_ff, res_total_ff;
   logic [IB-1:0]           res_tilt_ff;
   logic                    res_zero_ff;
   logic                    mem_we;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign csq     = fth_pkg::CSQ[mid_ff];
   assign mul_op  = (state_ff == B_PLO) ? HI_W'(csq[LO_W-1:0]) : csq[fth_pkg::CSQ_BITS-1:LO_W];
   assign prod    = (SW+HI_W)'(item_ff.sum_sq) * (SW+HI_W)'(mul_op);
   assign lhs     = CMP_W'({item_ff.z_sq, 60'b0});
   assign pred    = (lhs < rhs_ff) || (item_ff.z_pos && (lhs == rhs_ff));

   assign cur      = rd_valid_ff ? rd_ff : '0;
   assign sum      = SUM_W'(cur) + SUM_W'(item_ff.inc);
   assign total_in = (sum[SUM_W-1:TOTAL_BITS] != '0) ? '1 : sum[TOTAL_BITS-1:0];
   assign mem_we   = (state_ff == B_ADD);

   assign work_pop = (state_ff == B_IDLE) && !work_empty;
   assign res_push = (state_ff == B_EMIT) && !res_full;

   always_comb begin
      logic [TOTAL_BITS+OB-1:0] t_ext, p_ext;
      t_ext = (TOTAL_BITS+OB)'(res_total_ff);
      p_ext = (TOTAL_BITS+OB)'(peak_ff);
      res_data.tilt_bin    = res_tilt_ff;
      res_data.bin_total   = t_ext[OB-1:0];
      res_data.peak_total  = p_ext[OB-1:0];
      res_data.zero_normal = res_zero_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (!work_empty) begin
            if (work_data.zero) state_in = B_EMIT;
            else if (work_data.z_pos || work_data.z_neg) state_in = B_CHK;
            else state_in = B_READ;
         end
         B_CHK:   state_in = (lo_ff == hi_ff) ? B_READ : B_PLO;
         B_PLO:   state_in = B_PHI;
         B_PHI:   state_in = B_SUM;
         B_SUM:   state_in = B_CMP;
         B_CMP:   state_in = B_CHK;
         B_READ:  state_in = B_ADD;
         B_ADD:   state_in = B_EMIT;
         B_EMIT:  if (!res_full) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         lo_ff    <= '0;
         hi_ff    <= SB'(fth_pkg::HALF_RANGE + 1);
         valid_ff <= '0;
         peak_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (work_pop) begin
            lo_ff <= '0;
            hi_ff <= SB'(fth_pkg::HALF_RANGE + 1);
         end else if (state_ff == B_CMP) begin
            if (pred) lo_ff <= mid_ff + 1'b1;
            else hi_ff <= mid_ff;
         end
         if (mem_we) begin
            valid_ff[idx_ff] <= 1'b1;
            if (total_in > peak_ff) peak_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[idx_ff] <= total_in;
      rd_ff       <= mem[idx_ff];
      rd_valid_ff <= valid_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (work_pop) begin
         item_ff      <= work_data;
         idx_ff       <= IB'(fth_pkg::HALF_RANGE);
         res_zero_ff  <= work_data.zero;
         res_tilt_ff  <= '0;
         res_total_ff <= '0;
      end
      if (state_ff == B_CHK) begin
         mid_ff <= mid_sum[SB:1];
         if (lo_ff == hi_ff) begin
            // upward facing counts bins down from the top, downward from the bottom
            idx_ff <= item_ff.z_pos ? IB'(fth_pkg::BIN_COUNT) - IB'(lo_ff) : IB'(lo_ff);
         end
      end
      if (state_ff == B_PLO) plo_ff <= prod;
      if (state_ff == B_PHI) phi_ff <= prod;
      if (state_ff == B_SUM) rhs_ff <= (CMP_W'(phi_ff) << LO_W) + CMP_W'(plo_ff);
      if (mem_we) begin
         res_total_ff <= total_in;
         res_tilt_ff  <= idx_ff - IB'(fth_pkg::HALF_RANGE);
      end
   end

   `FTH_ASSERT_ALWAYS(a_search_order, clock, reset, lo_ff <= hi_ff, "search bounds crossed")
   `FTH_ASSERT_IMPLY(a_peak_covers, clock, reset, res_push && !res_zero_ff, peak_ff >= res_total_ff, "peak below bin total")
   `FTH_ASSERT_IMPLY(a_zero_result, clock, reset, res_push && res_zero_ff, res_total_ff == '0 && res_tilt_ff == '0, "zero normal result not clean")
   `FTH_ASSERT_NEXT(a_bin_marked, clock, reset, mem_we, valid_ff[$past(idx_ff)], "written bin not marked valid")
endmodule

[src/facet_tilt_histogram.sv]
// top level of the facet tilt histogram: front, work queue, back, result queue
// depends on fth_pkg, fth_fifo, fth_front and fth_back
//
// input side is a queue write port: an item (one facet normal, signed x, y, z)
//   is taken at a clock edge with push high and full low
// result side is a queue read port: while empty is low the oldest result
//   (tilt bin, bin total, peak total, zero flag) is on the rsp_ ports and
//   leaves at a clock edge with pop high
// the front squares and sums the components through one multiplier, then takes
//   the rounded square root one bit a cycle; it takes no new item until the last
//   one has gone to the work queue
// the back binary searches the cosine square table in steps of check, low product,
//   high product, sum and compare on one shared multiplier, then reads and writes
//   the bin; it takes no new item until it has emitted the last result; a normal
//   with zero z skips the search, a zero normal skips the search and the bin update
// a two entry queue sits between front and back and another on the result
//   side, so a stalled reader holds results while the block keeps working
//   until both queues fill; full is high while the front holds an item
// synchronous reset clears the control, the peak and the per-bin valid bits,
//   so every bin reads as zero with no clearing pass
module facet_tilt_histogram #(
   parameter int TOTAL_BITS = fth_pkg::TOTAL_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   output logic                                   full,
   input  logic signed [fth_pkg::NORMAL_BITS-1:0] req_normal_x,
   input  logic signed [fth_pkg::NORMAL_BITS-1:0] req_normal_y,
   input  logic signed [fth_pkg::NORMAL_BITS-1:0] req_normal_z,
   output logic                                   empty,
   input  logic                                   pop,
   output logic signed [fth_pkg::TILT_BITS-1:0]   rsp_tilt_bin,
   output logic [fth_pkg::OUT_BITS-1:0]           rsp_bin_total,
   output logic [fth_pkg::OUT_BITS-1:0]           rsp_peak_total,
   output logic                                   rsp_zero_normal
);
   localparam int WORK_W = $bits(fth_pkg::work_type);
   localparam int RES_W  = $bits(fth_pkg::result_type);

   // front to work queue
   logic                f_push, f_full;
   fth_pkg::work_type   f_data;
   // work queue to back
   logic                w_empty, w_pop;
   fth_pkg::work_type   w_data;
   // back to result queue
   logic                r_push, r_full;
   fth_pkg::result_type r_data, r_out;

   fth_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .normal_x  (req_normal_x),
      .normal_y  (req_normal_y),
      .normal_z  (req_normal_z),
      .work_push (f_push),
      .work_data (f_data),
      .work_full (f_full)
   );

   fth_fifo #(.WIDTH(WORK_W), .DEPTH(2)) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (f_data),
      .full      (f_full),
      .pop       (w_pop),
      .pop_data  (w_data),
      .empty     (w_empty)
   );

   fth_back #(.TOTAL_BITS(TOTAL_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .work_empty (w_empty),
      .work_pop   (w_pop),
      .work_data  (w_data),
      .res_push   (r_push),
      .res_data   (r_data),
      .res_full   (r_full)
   );

   // result queue keeps the back running while the reader stalls
   fth_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
      .clock     (clock),
      .reset     (reset),
      .push      (r_push),
      .push_data (r_data),
      .full      (r_full),
      .pop       (pop),
      .pop_data  (r_out),
      .empty     (empty)
   );

   assign rsp_tilt_bin    = r_out.tilt_bin;
   assign rsp_bin_total   = r_out.bin_total;
   assign rsp_peak_total  = r_out.peak_total;
   assign rsp_zero_normal = r_out.zero_normal;
endmodule
